[sv/bat_pkg.sv]
// ----------------------------------------------------------------------------
// bat_pkg
// Shared types and action codes for the breakpoint address table.
// ----------------------------------------------------------------------------
package bat_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned HITS_W = 32;
  localparam int unsigned ACT_W  = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD     = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_ENABLE  = 3'd2,
    ACT_DISABLE = 3'd3,
    ACT_HIT     = 3'd4,
    ACT_CLEAR   = 3'd5
  } action_t;

  // Contents of one table slot.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              en;
    logic [HITS_W-1:0] hits;
  } entry_t;

  // Command broadcast to every cell in the cycle a beat is accepted.
  typedef struct packed {
    logic              go;
    logic              add_ok;
    action_t           action;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

endpackage

[sv/bat_chan_if.sv]
// ----------------------------------------------------------------------------
// bat_chan_if
// Valid/ready channels carrying table commands and their results.
// ----------------------------------------------------------------------------
interface bat_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] address;

  modport source (output valid, action, address, input ready);
  modport sink   (input valid, action, address, output ready);
endinterface

interface bat_out_if #(
  parameter int unsigned COUNT_W = 5
);
  logic               valid;
  logic               ready;
  logic               ok;
  logic               matched;
  logic [31:0]        hit_total;
  logic [COUNT_W-1:0] entries_in_use;

  modport source (output valid, ok, matched, hit_total, entries_in_use, input ready);
  modport sink   (input valid, ok, matched, hit_total, entries_in_use, output ready);
endinterface

[sv/bat_cell.sv]
// ----------------------------------------------------------------------------
// bat_cell
// One table slot: compares its address, passes the first-match flag up the
// row and loads from its upper neighbor when a removal compacts the table.
// ----------------------------------------------------------------------------
module bat_cell
  import bat_pkg::*;
(
  input  logic              clk,
  input  cmd_t              cmd,
  input  logic              in_use,
  input  logic              is_tail,
  input  logic              found_in,
  input  entry_t            nbr,
  output entry_t            ent,
  output logic              found_out,
  output logic [HITS_W-1:0] hit_val
);

  entry_t            ent_r;
  entry_t            ent_nxt;
  logic              is_match;
  logic              is_first;
  logic [HITS_W-1:0] hits_inc;

  assign is_match  = in_use && (ent_r.addr == cmd.addr) &&
                     ((cmd.action != ACT_HIT) || ent_r.en);
  assign is_first  = is_match && !found_in;
  assign found_out = found_in || is_match;
  assign hits_inc  = ent_r.hits + HITS_W'(1);
  assign hit_val   = (is_first && (cmd.action == ACT_HIT)) ? hits_inc : '0;
  assign ent       = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.go) begin
      case (cmd.action)
        ACT_ADD: begin
          if (cmd.add_ok && is_tail) begin
            ent_nxt.addr = cmd.addr;
            ent_nxt.en   = 1'b1;
            ent_nxt.hits = '0;
          end
        end
        // Every slot at or above the removed one takes its neighbor's entry.
        ACT_REMOVE: begin
          if (found_out) begin
            ent_nxt = nbr;
          end
        end
        ACT_ENABLE, ACT_DISABLE: begin
          if (is_first) begin
            ent_nxt.en = (cmd.action == ACT_ENABLE);
          end
        end
        ACT_HIT: begin
          if (is_first) begin
            ent_nxt.hits = hits_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

[sv/breakpoint_address_table.sv]
// ----------------------------------------------------------------------------
// breakpoint_address_table
// Compacted table of breakpoint addresses with enable bits and hit counters.
// ----------------------------------------------------------------------------
// Commands enter on in_bus (action, address) and one result beat leaves on
// out_bus for each command: ok, matched, hit_total and entries_in_use.
// The table is a row of cells, one per slot; every cell compares its address
// in the same cycle and the first-match flag ripples up the row, so a command
// is resolved in the cycle it is accepted. The result is registered in the
// output register, and a new command is taken every cycle that the output
// register is empty or being drained. The rate is one command per cycle while
// the receiver keeps up, as the compare and first-match chain resolves each.
// A removal shifts every later slot down by one in that same cycle.
// Reset empties the table (entry count zero) and the output register; slot
// contents are not cleared since only slots below the count are looked at.
// When the receiver stalls, the result is held and in_bus.ready drops until
// the beat is taken.
// ----------------------------------------------------------------------------
module breakpoint_address_table
  import bat_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  bat_in_if.sink    in_bus,
  bat_out_if.source out_bus
);

  localparam int unsigned CNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned OUT_CNT_W = $bits(out_bus.entries_in_use);

  cmd_t              cmd;
  action_t           act;
  logic              accept;
  logic              any_match;
  logic              full;
  logic              ok;
  logic [HITS_W-1:0] hit_or;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic              ok_r;
  logic              matched_r;
  logic [HITS_W-1:0] hit_total_r;
  logic [CNT_W-1:0]  out_count_r;

  entry_t            ents   [MAX_ENTRIES];
  logic              found  [MAX_ENTRIES+1];
  logic [HITS_W-1:0] hvals  [MAX_ENTRIES];

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;
  assign act          = action_t'(in_bus.action);
  assign full         = (count_r == CNT_W'(MAX_ENTRIES));

  assign cmd.go     = accept;
  assign cmd.add_ok = !full && !any_match;
  assign cmd.action = act;
  assign cmd.addr   = in_bus.address;

  assign found[0]  = 1'b0;
  assign any_match = found[MAX_ENTRIES];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t nbr;
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign nbr = ents[i];
    end else begin : g_mid
      assign nbr = ents[i+1];
    end

    bat_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .in_use    (CNT_W'(i) < count_r),
      .is_tail   (CNT_W'(i) == count_r),
      .found_in  (found[i]),
      .nbr       (nbr),
      .ent       (ents[i]),
      .found_out (found[i+1]),
      .hit_val   (hvals[i])
    );
  end

  always_comb begin
    hit_or = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_or = hit_or | hvals[i];
    end
  end

  always_comb begin
    ok        = 1'b0;
    count_nxt = count_r;
    unique case (act)
      ACT_ADD: begin
        ok = cmd.add_ok;
        if (cmd.add_ok) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_REMOVE: begin
        ok = any_match;
        if (any_match) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      ACT_ENABLE, ACT_DISABLE, ACT_HIT: ok = any_match;
      ACT_CLEAR: begin
        ok        = 1'b1;
        count_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r        <= ok;
      matched_r   <= ok && (act == ACT_HIT);
      hit_total_r <= hit_or;
      out_count_r <= count_nxt;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.ok             = ok_r;
  assign out_bus.matched        = matched_r;
  assign out_bus.hit_total      = hit_total_r;
  assign out_bus.entries_in_use = OUT_CNT_W'(out_count_r);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && matched_r |-> ok_r)
    else $error("match reported without success");

  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !matched_r |-> hit_total_r == '0)
    else $error("hit total nonzero without a match");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (act == ACT_CLEAR) |=> out_valid_r && ok_r && (count_r == '0))
    else $error("clear did not empty the table");
`endif

endmodule
